FILE: rtl/core/hbs_pkg.sv
// ----------------------------------------------------------------------------
// hbs_pkg
// Types and codes shared by the heightfield bilinear sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

  localparam int CFG_DATA_W = 32;

  localparam logic CFG_GRID_RESOLUTION = 1'b0;
  localparam logic CFG_CELL_SIZE       = 1'b1;

  localparam logic [8:0]  GRID_RES_RESET  = 9'd129;
  localparam logic [31:0] CELL_SIZE_RESET = 32'd65536;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_SAMPLE = 2'd2,
    ACT_NORMAL = 2'd3
  } hbs_action_t;

  typedef struct packed {
    hbs_action_t        action;
    logic signed [15:0] row;
    logic signed [15:0] col;
    logic signed [31:0] height_in;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;
  } hbs_in_t;

  typedef struct packed {
    logic signed [31:0] height_out;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               write_done;
  } hbs_out_t;

endpackage

FILE: rtl/core/hbs_height_ram.sv
// ----------------------------------------------------------------------------
// hbs_height_ram
// Height store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hbs_height_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/hbs_divider.sv
// ----------------------------------------------------------------------------
// hbs_divider
// Restoring divider, one quotient bit per cycle. The upper DW bits of the
// dividend must be below the divisor.
// ----------------------------------------------------------------------------
module hbs_divider #(
  parameter int QW = 24,
  parameter int DW = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [QW+DW-1:0] numer,
  input  logic [DW-1:0]    divisor,
  output logic             done,
  output logic [QW-1:0]    quot
);

  localparam int CW = $clog2(QW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [QW-1:0] lo;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem, lo[QW-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign quot  = lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= numer[QW+DW-1:QW];
        lo   <= numer[QW-1:0];
        dvs  <= divisor;
        cnt  <= CW'(QW - 1);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
        lo  <= {lo[QW-2:0], ge};
        cnt <= cnt - CW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/hbs_sqrt.sv
// ----------------------------------------------------------------------------
// hbs_sqrt
// Floor square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module hbs_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] rad;
  logic [34:0] rem;
  logic [34:0] trial;
  logic [34:0] tsub;
  logic        ge;

  assign trial = {rem[32:0], rad[63:62]};
  assign tsub  = {1'b0, root, 2'b01};
  assign ge    = trial >= tsub;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= 5'd31;
        busy <= 1'b1;
      end else if (busy) begin
        rad  <= {rad[61:0], 2'b00};
        rem  <= ge ? trial - tsub : trial;
        root <= {root[30:0], ge};
        cnt  <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/heightfield_bilinear_sampler.sv
// ----------------------------------------------------------------------------
// heightfield_bilinear_sampler
// Square height grid with write, read, bilinear sample and normal actions.
// ----------------------------------------------------------------------------
// Items arrive on in_valid/in_ready and results leave on out_valid/out_ready,
// one result per item, in order. The block works on one item at a time; a
// finished result waits in the output register while the next item is taken.
// After reset a clearing pass zeroes the height memory, all MAX_RESOLUTION^2
// words (65536 by default), with in_ready low; configuration writes are
// taken at any time and take effect at once, also on an item in progress.
// Steps from acceptance to out_valid:
//   write  memory write at acceptance
//   read   one memory read
//   sample two passes of the bit-serial divider
//          (one quotient bit a cycle) plus four memory reads and three blends
//   normal four memory reads, the normalising shift
//          (one bit a cycle), the square root (one bit a cycle) and three
//          divider passes
// The height memory has a single read port and the divider is shared by
// sample and normal. A stalled receiver holds the result; the block then
// finishes its current item and waits before delivering it.
// ----------------------------------------------------------------------------
module heightfield_bilinear_sampler #(
  parameter int MAX_RESOLUTION = 256,
  parameter int FRAC_BITS      = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  hbs_pkg::hbs_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output hbs_pkg::hbs_out_t                out_data,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [hbs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import hbs_pkg::*;

  localparam int IW    = $clog2(MAX_RESOLUTION);
  localparam int RW    = IW + 1;
  localparam int DEPTH = MAX_RESOLUTION * MAX_RESOLUTION;
  localparam int AW    = $clog2(DEPTH);
  localparam int QW    = (IW + FRAC_BITS > 16) ? IW + FRAC_BITS : 16;
  localparam int NW    = QW + 32;
  localparam int PW    = IW + 32;
  localparam int FW    = FRAC_BITS + 1;
  localparam int PRW   = 33 + FW + 1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_PREP, S_CLAMP, S_DIVX, S_DIVZ, S_INDEX, S_FETCH, S_FWAIT,
    S_BMUL, S_BADD, S_NVEC, S_NSHIFT, S_SQMUL, S_SQADD, S_SQRT, S_QDIV, S_FIN
  } state_t;

  typedef struct packed {
    logic signed [1:0] drow;
    logic signed [1:0] dcol;
  } offset_t;

  typedef struct packed {
    logic [IW-1:0] idx;
    logic [FW-1:0] frac;
  } split_t;

  function automatic logic [IW-1:0] clamp_idx(input logic signed [16:0] v,
                                               input logic [RW-1:0] r);
    logic signed [17:0] vs;
    logic signed [17:0] rm;
    vs = 18'(v);
    rm = $signed(18'(r)) - 18'sd1;
    if (vs < 18'sd0) return '0;
    else if (vs > rm) return rm[IW-1:0];
    else return vs[IW-1:0];
  endfunction

  function automatic logic [PW-1:0] clamp_pos(input logic signed [31:0] p,
                                              input logic [PW-1:0] mx);
    logic [PW-1:0] pz;
    pz = {{(PW-32){1'b0}}, p};
    if (p < 32'sd0) return '0;
    else if (pz > mx) return mx;
    else return pz;
  endfunction

  function automatic split_t split_q(input logic [QW-1:0] q,
                                     input logic [RW-1:0] lim);
    split_t        s;
    logic [QW-1:0] base;
    base = QW'({lim, {FRAC_BITS{1'b0}}});
    if (q[QW-1:FRAC_BITS] > (QW-FRAC_BITS)'(lim)) begin
      s.idx  = IW'(lim);
      s.frac = FW'(q - base);
    end else begin
      s.idx  = IW'(q[QW-1:FRAC_BITS]);
      s.frac = {1'b0, q[FRAC_BITS-1:0]};
    end
    return s;
  endfunction

  function automatic offset_t fetch_off(input hbs_action_t a, input logic [1:0] k);
    offset_t o;
    o = '0;
    if (a == ACT_NORMAL) begin
      case (k)
        2'd0:    o = '{drow: 2'sd0,  dcol: -2'sd1};
        2'd1:    o = '{drow: 2'sd0,  dcol: 2'sd1};
        2'd2:    o = '{drow: -2'sd1, dcol: 2'sd0};
        default: o = '{drow: 2'sd1,  dcol: 2'sd0};
      endcase
    end else if (a == ACT_SAMPLE) begin
      o = '{drow: $signed({1'b0, k[1]}), dcol: $signed({1'b0, k[0]})};
    end
    return o;
  endfunction

  function automatic logic [15:0] to_q15(input logic [QW-1:0] q, input logic neg);
    logic [15:0] ql;
    ql = q[15:0];
    if (!neg) return (q > QW'(32767)) ? 16'h7FFF : ql;
    else return (q > QW'(32768)) ? 16'h8000 : 16'(~ql + 16'd1);
  endfunction

  // configuration
  logic [8:0]  grid_resolution;
  logic [31:0] cell_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_resolution <= GRID_RES_RESET;
      cell_size       <= CELL_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_RESOLUTION: grid_resolution <= cfg_data[8:0];
        CFG_CELL_SIZE:       cell_size       <= cfg_data[31:0];
        default:             ;
      endcase
    end
  end

  logic [RW-1:0] r_eff;
  logic [RW-1:0] lim;
  logic [31:0]   c_eff;

  always_comb begin
    if (grid_resolution < 9'd2) r_eff = RW'(2);
    else if (32'(grid_resolution) > MAX_RESOLUTION) r_eff = RW'(MAX_RESOLUTION);
    else r_eff = RW'(grid_resolution);
    lim   = r_eff - RW'(2);
    c_eff = (cell_size == 32'd0) ? 32'd1 : cell_size;
  end

  // registers
  state_t             state;
  logic [AW-1:0]      clr_cnt;
  hbs_action_t        act;
  logic [1:0]         k;
  logic [1:0]         klast;
  logic               cap_valid;
  logic [1:0]         cap_idx;
  logic signed [16:0] base_row;
  logic signed [16:0] base_col;
  logic signed [31:0] pos_x_q;
  logic signed [31:0] pos_z_q;
  logic [PW-1:0]      maxc;
  logic [PW-1:0]      pxc;
  logic [PW-1:0]      pzc;
  logic [QW-1:0]      qx;
  logic [FW-1:0]      fx;
  logic [FW-1:0]      fz;
  logic signed [31:0] h [4];
  logic signed [31:0] north;
  logic [1:0]         bsel;
  logic signed [31:0] bl_a;
  logic signed [PRW-1:0] prod;
  logic [33:0]        m0, m1, m2;
  logic               vneg0, vneg1, vneg2;
  logic [1:0]         sq_i;
  logic [61:0]        sqp;
  logic [63:0]        sum;
  logic [31:0]        len;
  logic [1:0]         qi;
  logic               div_run;
  logic               sqrt_run;
  hbs_out_t           res;

  // memory
  logic [31:0]        rdata;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [31:0]        ram_wdata;
  logic [AW-1:0]      ram_raddr;

  logic               accept;
  logic signed [17:0] wrow, wcol;
  logic               wr_ok;
  logic [IW+RW-1:0]   wr_lin;
  offset_t            off;
  logic [IW-1:0]      frow, fcol;
  logic [IW+RW-1:0]   rd_lin;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    wrow   = 18'(in_data.row);
    wcol   = 18'(in_data.col);
    wr_ok  = (wrow >= 18'sd0) && (wrow < $signed(18'(r_eff))) &&
             (wcol >= 18'sd0) && (wcol < $signed(18'(r_eff)));
    wr_lin = wrow[IW-1:0] * r_eff + wcol[IW-1:0];
    off    = fetch_off(act, k);
    frow   = clamp_idx(base_row + 17'(off.drow), r_eff);
    fcol   = clamp_idx(base_col + 17'(off.dcol), r_eff);
    rd_lin = frow * r_eff + fcol;
  end

  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end else begin
      ram_we    = accept && (in_data.action == ACT_WRITE) && wr_ok;
      ram_waddr = AW'(wr_lin);
      ram_wdata = in_data.height_in;
    end
    ram_raddr = AW'(rd_lin);
  end

  hbs_height_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // divider (shared by sample and normal) and square root
  logic          div_start, div_done;
  logic [NW-1:0] div_numer;
  logic [31:0]   div_dvs;
  logic [QW-1:0] div_quot;
  logic          sqrt_start, sqrt_done;
  logic [31:0]   sqrt_root;

  always_comb begin
    div_start = ((state == S_DIVX) || (state == S_DIVZ) || (state == S_QDIV)) && !div_run;
    case (state)
      S_DIVX:  div_numer = NW'({pxc, {FRAC_BITS{1'b0}}});
      S_DIVZ:  div_numer = NW'({pzc, {FRAC_BITS{1'b0}}});
      default: div_numer = NW'({m0[30:0], 15'd0}) + NW'(len[31:1]);
    endcase
    div_dvs    = (state == S_QDIV) ? len : c_eff;
    sqrt_start = (state == S_SQRT) && !sqrt_run;
  end

  hbs_divider #(.QW(QW), .DW(32)) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .numer   (div_numer),
    .divisor (div_dvs),
    .done    (div_done),
    .quot    (div_quot)
  );

  hbs_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sum),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // datapath helpers
  split_t                sx, sz;
  logic signed [31:0]    ba, bb;
  logic [FW-1:0]         bt;
  logic signed [32:0]    bdiff;
  logic signed [PRW-1:0] bsum;
  logic signed [32:0]    d0, d2;
  logic [32:0]           a0, a2;
  logic [33:0]           top;
  logic [15:0]           comp;

  always_comb begin
    sx = split_q(qx, lim);
    sz = split_q(div_quot, lim);
    case (bsel)
      2'd0:    begin ba = h[0];  bb = h[1];  bt = fx; end
      2'd1:    begin ba = h[2];  bb = h[3];  bt = fx; end
      default: begin ba = north; bb = res.height_out; bt = fz; end
    endcase
    bdiff = 33'(bb) - 33'(ba);
    bsum  = PRW'(bl_a) + (prod >>> FRAC_BITS);
    d0    = 33'(h[0]) - 33'(h[1]);
    d2    = 33'(h[2]) - 33'(h[3]);
    a0    = d0[32] ? 33'(-d0) : 33'(d0);
    a2    = d2[32] ? 33'(-d2) : 33'(d2);
    top   = m0;
    if (m1 > top) top = m1;
    if (m2 > top) top = m2;
    comp  = to_q15(div_quot, vneg0);
  end

  always_ff @(posedge clk) begin
    if (cap_valid) begin
      h[cap_idx] <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      cap_valid <= 1'b0;
      div_run   <= 1'b0;
      sqrt_run  <= 1'b0;
    end else begin
      cap_valid <= (state == S_FETCH);
      cap_idx   <= k;
      if (div_start) div_run <= 1'b1;
      if (div_done) div_run <= 1'b0;
      if (sqrt_start) sqrt_run <= 1'b1;
      if (sqrt_done) sqrt_run <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;

      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            act      <= in_data.action;
            base_row <= 17'(in_data.row);
            base_col <= 17'(in_data.col);
            pos_x_q  <= in_data.pos_x;
            pos_z_q  <= in_data.pos_z;
            k        <= 2'd0;
            res      <= '0;
            case (in_data.action)
              ACT_WRITE: begin
                res.write_done <= wr_ok;
                state          <= S_FIN;
              end
              ACT_READ: begin
                klast <= 2'd0;
                state <= S_FETCH;
              end
              ACT_SAMPLE: state <= S_PREP;
              default: begin
                klast <= 2'd3;
                state <= S_FETCH;
              end
            endcase
          end
        end
        S_PREP: begin
          maxc  <= (r_eff - RW'(1)) * c_eff;
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          pxc   <= clamp_pos(pos_x_q, maxc);
          pzc   <= clamp_pos(pos_z_q, maxc);
          state <= S_DIVX;
        end
        S_DIVX: begin
          if (div_done) begin
            qx    <= div_quot;
            state <= S_DIVZ;
          end
        end
        S_DIVZ: begin
          if (div_done) begin
            base_col <= $signed(17'(sx.idx));
            fx       <= sx.frac;
            base_row <= $signed(17'(sz.idx));
            fz       <= sz.frac;
            state    <= S_INDEX;
          end
        end
        S_INDEX: begin
          k     <= 2'd0;
          klast <= 2'd3;
          state <= S_FETCH;
        end
        S_FETCH: begin
          k <= k + 2'd1;
          if (k == klast) state <= S_FWAIT;
        end
        S_FWAIT: begin
          case (act)
            ACT_READ: begin
              res.height_out <= rdata;
              state          <= S_FIN;
            end
            ACT_SAMPLE: begin
              bsel  <= 2'd0;
              state <= S_BMUL;
            end
            default: state <= S_NVEC;
          endcase
        end
        S_BMUL: begin
          prod  <= bdiff * $signed({1'b0, bt});
          bl_a  <= ba;
          state <= S_BADD;
        end
        S_BADD: begin
          case (bsel)
            2'd0: begin
              north <= bsum[31:0];
              bsel  <= 2'd1;
              state <= S_BMUL;
            end
            2'd1: begin
              res.height_out <= bsum[31:0];
              bsel           <= 2'd2;
              state          <= S_BMUL;
            end
            default: begin
              res.height_out <= bsum[31:0];
              state          <= S_FIN;
            end
          endcase
        end
        S_NVEC: begin
          m0    <= {1'b0, a0};
          m1    <= {1'b0, c_eff, 1'b0};
          m2    <= {1'b0, a2};
          vneg0 <= d0[32];
          vneg1 <= 1'b0;
          vneg2 <= d2[32];
          state <= S_NSHIFT;
        end
        S_NSHIFT: begin
          if (top < 34'd1073741824) begin
            m0 <= m0 << 1;
            m1 <= m1 << 1;
            m2 <= m2 << 1;
          end else if (top >= 34'd2147483648) begin
            m0 <= m0 >> 1;
            m1 <= m1 >> 1;
            m2 <= m2 >> 1;
          end else begin
            sq_i  <= 2'd0;
            sum   <= '0;
            state <= S_SQMUL;
          end
        end
        S_SQMUL: begin
          sqp   <= m0[30:0] * m0[30:0];
          state <= S_SQADD;
        end
        S_SQADD: begin
          sum <= sum + 64'(sqp);
          m0  <= m1;
          m1  <= m2;
          m2  <= m0;
          if (sq_i == 2'd2) begin
            state <= S_SQRT;
          end else begin
            sq_i  <= sq_i + 2'd1;
            state <= S_SQMUL;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            len   <= sqrt_root;
            qi    <= 2'd0;
            state <= S_QDIV;
          end
        end
        S_QDIV: begin
          if (div_done) begin
            case (qi)
              2'd0:    res.normal_x <= comp;
              2'd1:    res.normal_y <= comp;
              default: res.normal_z <= comp;
            endcase
            m0    <= m1;
            m1    <= m2;
            m2    <= m0;
            vneg0 <= vneg1;
            vneg1 <= vneg2;
            vneg2 <= vneg0;
            if (qi == 2'd2) state <= S_FIN;
            else qi <= qi + 2'd1;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the heightfield bilinear sampler: drives write,
// read, sample and normal transactions under several grid settings and
// compares every result with an internal model of the height grid.
// ----------------------------------------------------------------------------
module tb_top;
  import hbs_pkg::*;

  localparam int MAXRES = 256;
  localparam int WDOG_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  hbs_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hbs_out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  heightfield_bilinear_sampler dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  logic [31:0] grid [0:MAXRES*MAXRES-1];
  logic [8:0]  res_reg;
  logic [31:0] cell_reg;
  hbs_out_t    pending_results [$];
  int          fail_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          quiet_cycles = 0;

  function automatic longint eff_res();
    longint r;
    r = res_reg;
    if (r < 2) r = 2;
    if (r > MAXRES) r = MAXRES;
    return r;
  endfunction

  function automatic longint eff_cell();
    return (cell_reg == 0) ? 64'sd1 : longint'(cell_reg);
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint grid_at(longint row, longint col);
    longint r;
    r = eff_res();
    row = clampl(row, 0, r - 1);
    col = clampl(col, 0, r - 1);
    return longint'($signed(grid[row * r + col]));
  endfunction

  function automatic longint floor_shr(longint v);
    if (v >= 0) return v >>> 16;
    return -((-v + 65535) >>> 16);
  endfunction

  function automatic longint lerp(longint a, longint b, longint t);
    return a + floor_shr((b - a) * t);
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] acc, bit_w;
    acc = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= acc + bit_w) begin
        v -= acc + bit_w;
        acc = (acc >> 1) + bit_w;
      end else begin
        acc >>= 1;
      end
      bit_w >>= 2;
    end
    return acc;
  endfunction

  function automatic logic [15:0] unit_q15(longint v, logic [63:0] mag, logic [63:0] len);
    logic [63:0] q;
    longint s;
    q = (mag * 64'd32768 + len / 2) / len;
    s = (v < 0) ? -longint'(q) : longint'(q);
    s = clampl(s, -32768, 32767);
    return s[15:0];
  endfunction

  function automatic hbs_out_t predict_result(hbs_in_t it);
    hbs_out_t o;
    longint r, c, maxc, px, pz, cx, cz, fx, fz, n, s, row, col;
    longint v [3];
    logic [63:0] m [3];
    logic [63:0] top, sum, len;
    o = '0;
    r = eff_res();
    c = eff_cell();
    row = it.row;
    col = it.col;
    case (it.action)
      ACT_WRITE: begin
        if (row >= 0 && row < r && col >= 0 && col < r) begin
          grid[row * r + col] = it.height_in;
          o.write_done = 1'b1;
        end
      end
      ACT_READ: o.height_out = 32'(grid_at(row, col));
      ACT_SAMPLE: begin
        maxc = (r - 1) * c;
        px = clampl(longint'(it.pos_x), 0, maxc);
        pz = clampl(longint'(it.pos_z), 0, maxc);
        cx = px / c;
        cz = pz / c;
        if (cx > r - 2) cx = r - 2;
        if (cz > r - 2) cz = r - 2;
        fx = ((px - cx * c) << 16) / c;
        fz = ((pz - cz * c) << 16) / c;
        n = lerp(grid_at(cz, cx), grid_at(cz, cx + 1), fx);
        s = lerp(grid_at(cz + 1, cx), grid_at(cz + 1, cx + 1), fx);
        o.height_out = 32'(lerp(n, s, fz));
      end
      default: begin
        v[0] = grid_at(row, col - 1) - grid_at(row, col + 1);
        v[1] = 2 * c;
        v[2] = grid_at(row - 1, col) - grid_at(row + 1, col);
        for (int i = 0; i < 3; i++) m[i] = v[i] < 0 ? -v[i] : v[i];
        top = m[0];
        if (m[1] > top) top = m[1];
        if (m[2] > top) top = m[2];
        while (top < (64'd1 << 30)) begin
          top <<= 1;
          for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        while (top >= (64'd1 << 31)) begin
          top >>= 1;
          for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) sum += m[i] * m[i];
        len = root64(sum);
        o.normal_x = unit_q15(v[0], m[0], len);
        o.normal_y = unit_q15(v[1], m[1], len);
        o.normal_z = unit_q15(v[2], m[2], len);
      end
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    hbs_out_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_data.height_out !== want.height_out)
            report_mismatch("height_out", out_data.height_out, want.height_out);
          if (out_data.normal_x !== want.normal_x)
            report_mismatch("normal_x", out_data.normal_x, want.normal_x);
          if (out_data.normal_y !== want.normal_y)
            report_mismatch("normal_y", out_data.normal_y, want.normal_y);
          if (out_data.normal_z !== want.normal_z)
            report_mismatch("normal_z", out_data.normal_z, want.normal_z);
          if (out_data.write_done !== want.write_done)
            report_mismatch("write_done", out_data.write_done, want.write_done);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // valid stays high after acceptance until the next idle or drain drops it
  task automatic send_item(hbs_in_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_result(it));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_GRID_RESOLUTION) res_reg = value[8:0];
    else cell_reg = value;
    @(posedge clk);
  endtask

  function automatic hbs_in_t make_item(hbs_action_t a, int row, int col,
                                        int h, int px, int pz);
    hbs_in_t it;
    it.action = a;
    it.row = 16'(row);
    it.col = 16'(col);
    it.height_in = h;
    it.pos_x = px;
    it.pos_z = pz;
    return it;
  endfunction

  function automatic int rand_index();
    int r;
    r = int'(eff_res());
    case ($urandom_range(9))
      0: return int'($urandom) - 32'sd0;
      1: return -int'($urandom_range(3));
      2: return r - 1 + $urandom_range(2);
      default: return $urandom_range(r - 1);
    endcase
  endfunction

  function automatic int rand_height();
    case ($urandom_range(3))
      0: return $urandom;
      1: return int'($urandom_range(1 << 20)) - (1 << 19);
      default: return int'($urandom_range(4000)) - 2000;
    endcase
  endfunction

  function automatic int rand_pos();
    longint ext;
    ext = (eff_res() - 1) * eff_cell();
    if (ext > 64'sh7fffffff) ext = 64'sh7fffffff;
    case ($urandom_range(7))
      0: return $urandom;
      1: return -int'($urandom_range(1000));
      default: return int'($urandom_range(int'(ext)));
    endcase
  endfunction

  function automatic hbs_in_t rand_item();
    return make_item(hbs_action_t'($urandom_range(3)), rand_index(), rand_index(),
                     rand_height(), rand_pos(), rand_pos());
  endfunction

  task automatic test_directed();
    send_item(make_item(ACT_NORMAL, 5, 5, 0, 0, 0));
    send_item(make_item(ACT_WRITE, 0, 0, 32'h7fffffff, 0, 0));
    send_item(make_item(ACT_WRITE, 0, 1, 32'h80000000, 0, 0));
    send_item(make_item(ACT_WRITE, 1, 0, 32'h00010000, 0, 0));
    send_item(make_item(ACT_WRITE, 1, 1, -32'sh30000, 0, 0));
    send_item(make_item(ACT_WRITE, -1, 0, 5, 0, 0));
    send_item(make_item(ACT_WRITE, 0, 129, 5, 0, 0));
    send_item(make_item(ACT_WRITE, 32767, -32768, 5, 0, 0));
    send_item(make_item(ACT_READ, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_READ, -32768, 32767, 0, 0, 0));
    send_item(make_item(ACT_READ, 32767, 32767, 0, 0, 0));
    send_item(make_item(ACT_SAMPLE, 0, 0, 0, 32'h8000, 32'h8000));
    send_item(make_item(ACT_SAMPLE, 0, 0, 0, 32'h80000000, 32'h7fffffff));
    send_item(make_item(ACT_SAMPLE, 0, 0, 0, 128 << 16, 128 << 16));
    send_item(make_item(ACT_SAMPLE, 0, 0, 0, 32'hffff, 32'h10000));
    send_item(make_item(ACT_NORMAL, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_NORMAL, 1, 1, 0, 0, 0));
    send_item(make_item(ACT_NORMAL, -32768, 32767, 0, 0, 0));
    drain();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_item(rand_item());
  endtask

  task automatic test_settings();
    write_cfg(CFG_GRID_RESOLUTION, 2);
    write_cfg(CFG_CELL_SIZE, 32'hffffffff);
    test_random(60);
    write_cfg(CFG_GRID_RESOLUTION, 0);
    write_cfg(CFG_CELL_SIZE, 0);
    test_random(60);
    write_cfg(CFG_GRID_RESOLUTION, 9'h1ff);
    write_cfg(CFG_CELL_SIZE, 1);
    test_random(60);
    write_cfg(CFG_GRID_RESOLUTION, 256);
    write_cfg(CFG_CELL_SIZE, 32'h00028000);
    test_random(60);
    write_cfg(CFG_GRID_RESOLUTION, 5);
    write_cfg(CFG_CELL_SIZE, $urandom);
    test_random(80);
    write_cfg(CFG_GRID_RESOLUTION, 3 + $urandom_range(20));
    write_cfg(CFG_CELL_SIZE, $urandom_range(32'h40000, 1));
    test_random(80);
  endtask

  initial begin
    for (int i = 0; i < MAXRES * MAXRES; i++) grid[i] = '0;
    res_reg  = GRID_RES_RESET;
    cell_reg = CELL_SIZE_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 32;
    recv_idle_pct = 71;
    test_directed();
    test_random(150);
    drain();
    send_idle_pct = 71;
    recv_idle_pct = 32;
    test_settings();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_cfg(CFG_GRID_RESOLUTION, 4);
    write_cfg(CFG_CELL_SIZE, 32'h10000);
    test_random(230);
    drain();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
